>>> rtl/lph_pkg.sv
// Shared constants, status codes and controller/datapath interface types.
`timescale 1ns / 1ps
package lph_pkg;

   localparam int MAX_SLOTS     = 1024;
   localparam int SLOT_W        = $clog2(MAX_SLOTS);
   localparam int SIZE_W        = SLOT_W + 1;
   localparam int LOAD_DIV      = 2;
   localparam int KEY_CAP       = MAX_SLOTS / LOAD_DIV;
   localparam int KEY_IDX_W     = $clog2(KEY_CAP);
   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_W         = 256;
   localparam int KB_W          = 6;
   localparam int SLOT_ALIGN    = 8;
   localparam int HASH_W        = 64;
   localparam int HBIT_W        = $clog2(HASH_W);
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BYTES    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ENABLE = 2'd2;

   localparam logic [2:0] ST_NOT_FOUND = 3'd0;
   localparam logic [2:0] ST_FOUND     = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_PRESENT   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_READ_ONLY = 3'd5;

   typedef struct packed {
      logic accept;
      logic mod_step;
      logic clr_step;
      logic insert;
      logic hit;
      logic advance;
      logic exhaust;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic mod_done;
      logic clr_done;
      logic slot_empty;
      logic key_match;
      logic probe_last;
      logic mode;
   } stat_type;

endpackage

>>> rtl/linear_probe_hash_set.sv
// Top level of the linear-probing hash set.
`timescale 1ns / 1ps
// Hash set of keys up to 32 bytes with lookup and insert. A transaction is
// taken when start is high and busy is low; its single result appears on the
// rsp_ ports for exactly one cycle, flagged by rsp_valid, and the receiver
// cannot stall it. After reset the slot table is cleared by a pass over all
// 1024 slots, during which busy stays high (csr writes are still taken). A
// refused insert (read-only or half load) answers in the cycle right after
// it is taken. Any other transaction runs the bit-serial hash remainder,
// then slot read, slot check and key compare per occupied slot it compares,
// and slot read and slot check for an empty slot that ends the probe, then
// its result. Write csr registers only while busy is low.
module linear_probe_hash_set (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lph_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [63:0]                    req_key_word0,
   input  logic [63:0]                    req_key_word1,
   input  logic [63:0]                    req_key_word2,
   input  logic [63:0]                    req_key_word3,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_status,
   output logic [9:0]                     rsp_slot_index,
   output logic [9:0]                     rsp_entry_count
);

   lph_pkg::cmd_type  cmd;
   lph_pkg::stat_type stat;

   // sequencer: clear pass, hash, probe loop, result strobe
   lph_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy),
      .done  (rsp_valid)
   );

   // storage, remainder unit and result registers
   lph_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_mode        (req_mode),
      .req_key_word0   (req_key_word0),
      .req_key_word1   (req_key_word1),
      .req_key_word2   (req_key_word2),
      .req_key_word3   (req_key_word3),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

>>> rtl/lph_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lph_ctrl.sv
// Sequencer for clearing, hashing and probing.
`timescale 1ns / 1ps
module lph_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  lph_pkg::stat_type stat,
   output lph_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              done
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_SRD   = 3'd3;
   localparam logic [2:0] S_SCHK  = 3'd4;
   localparam logic [2:0] S_KCHK  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = stat.early ? S_DONE : S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) state_in = S_SRD;
         end
         S_SRD: state_in = S_SCHK;
         S_SCHK: begin
            if (stat.slot_empty) begin
               cmd.insert = stat.mode;
               state_in   = S_DONE;
            end else begin
               state_in = S_KCHK;
            end
         end
         S_KCHK: begin
            priority if (stat.key_match) begin
               cmd.hit  = 1'b1;
               state_in = S_DONE;
            end else if (stat.probe_last) begin
               cmd.exhaust = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_SRD;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

endmodule

>>> rtl/lph_dp.sv
// Datapath: configuration, remainder unit, slot table, key store and result registers.
`timescale 1ns / 1ps
module lph_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lph_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_mode,
   input  logic [63:0]                    req_key_word0,
   input  logic [63:0]                    req_key_word1,
   input  logic [63:0]                    req_key_word2,
   input  logic [63:0]                    req_key_word3,
   input  lph_pkg::cmd_type               cmd,
   output lph_pkg::stat_type              stat,
   output logic [2:0]                     rsp_status,
   output logic [9:0]                     rsp_slot_index,
   output logic [9:0]                     rsp_entry_count
);

   localparam int SW = lph_pkg::SIZE_W;
   localparam int LW = lph_pkg::SLOT_W;
   localparam int KW = lph_pkg::KEY_W;
   localparam int IW = lph_pkg::KEY_IDX_W;

   logic [SW-1:0]  tsize_ff;
   logic [5:0]     kbytes_ff;
   logic           wen_ff;
   logic           mode_ff;
   logic [KW-1:0]  key_ff;
   logic [lph_pkg::HBIT_W-1:0] mcnt_ff;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [LW-1:0]  h_ff;
   logic [SW-1:0]  probe_ff;
   logic [LW-1:0]  clr_ff;
   logic [LW-1:0]  count_ff;
   logic [2:0]     status_ff;
   logic [LW-1:0]  slot_ff;

   logic [SW-1:0]  size_eff, s_al, h_inc;
   logic [5:0]     kb_eff;
   logic [SW:0]    rem_sh;
   logic [LW-1:0]  slot_rd;
   logic [KW-1:0]  key_rd;
   logic [LW-1:0]  slot_wa, slot_wd;
   logic           slot_we, mismatch;
   logic [LW-1:0]  v_m1;

   always_comb begin
      s_al = {tsize_ff[SW-1:3], 3'b000};
      priority if (s_al < SW'(lph_pkg::SLOT_ALIGN)) size_eff = SW'(lph_pkg::SLOT_ALIGN);
      else if (s_al > SW'(lph_pkg::MAX_SLOTS)) size_eff = SW'(lph_pkg::MAX_SLOTS);
      else size_eff = s_al;
      priority if (kbytes_ff == 6'd0) kb_eff = 6'd1;
      else if (kbytes_ff > 6'(lph_pkg::MAX_KEY_BYTES)) kb_eff = 6'(lph_pkg::MAX_KEY_BYTES);
      else kb_eff = kbytes_ff;
   end

   // one restoring remainder step per cycle, hash MSB first
   always_comb begin
      rem_sh = {rem_ff, key_ff[KW-1-(lph_pkg::HASH_W-1) + 6'(lph_pkg::HASH_W-1) - mcnt_ff]};
      if (rem_sh >= {1'b0, size_eff}) rem_in = SW'(rem_sh - {1'b0, size_eff});
      else rem_in = rem_sh[SW-1:0];
   end

   assign h_inc = {1'b0, h_ff} + SW'(1);

   always_comb begin
      mismatch = 1'b0;
      for (int b = 0; b < lph_pkg::MAX_KEY_BYTES; b++) begin
         if (6'(b) < kb_eff && key_rd[KW-1-8*b -: 8] != key_ff[KW-1-8*b -: 8]) mismatch = 1'b1;
      end
   end

   assign v_m1    = slot_rd - LW'(1);
   assign slot_we = cmd.clr_step | cmd.insert;
   assign slot_wa = cmd.clr_step ? clr_ff : h_ff;
   assign slot_wd = cmd.clr_step ? '0 : count_ff + LW'(1);

   lph_ram #(.WIDTH(LW), .DEPTH(lph_pkg::MAX_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (h_ff),
      .rd_data (slot_rd)
   );

   lph_ram #(.WIDTH(KW), .DEPTH(lph_pkg::KEY_CAP)) u_keys (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (key_ff),
      .rd_addr (v_m1[IW-1:0]),
      .rd_data (key_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff  <= SW'(lph_pkg::SLOT_ALIGN);
         kbytes_ff <= 6'(lph_pkg::MAX_KEY_BYTES);
         wen_ff    <= 1'b1;
         count_ff  <= '0;
         clr_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               lph_pkg::CSR_TABLE_SIZE:   tsize_ff  <= csr_data[SW-1:0];
               lph_pkg::CSR_KEY_BYTES:    kbytes_ff <= csr_data[5:0];
               lph_pkg::CSR_WRITE_ENABLE: wen_ff    <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.clr_step) clr_ff <= clr_ff + LW'(1);
         if (cmd.insert) count_ff <= count_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         key_ff   <= {req_key_word0, req_key_word1, req_key_word2, req_key_word3};
         mcnt_ff  <= '0;
         rem_ff   <= '0;
         probe_ff <= '0;
         slot_ff  <= '0;
         priority if (req_mode && !wen_ff) status_ff <= lph_pkg::ST_READ_ONLY;
         else if (req_mode && stat.early) status_ff <= lph_pkg::ST_FULL;
         else status_ff <= req_mode ? lph_pkg::ST_INSERTED : lph_pkg::ST_NOT_FOUND;
      end
      if (cmd.mod_step) begin
         mcnt_ff <= mcnt_ff + lph_pkg::HBIT_W'(1);
         rem_ff  <= rem_in;
         h_ff    <= rem_in[LW-1:0];
      end
      if (cmd.insert) slot_ff <= h_ff;
      if (cmd.hit) begin
         slot_ff   <= h_ff;
         status_ff <= mode_ff ? lph_pkg::ST_PRESENT : lph_pkg::ST_FOUND;
      end
      if (cmd.exhaust) status_ff <= mode_ff ? lph_pkg::ST_FULL : lph_pkg::ST_NOT_FOUND;
      if (cmd.advance) begin
         probe_ff <= probe_ff + SW'(1);
         h_ff     <= (h_inc == size_eff) ? '0 : h_inc[LW-1:0];
      end
   end

   always_comb begin
      stat.early      = req_mode && (!wen_ff || ({1'b0, count_ff} >= (size_eff >> 1)));
      stat.mod_done   = (mcnt_ff == lph_pkg::HBIT_W'(lph_pkg::HASH_W - 1));
      stat.clr_done   = (clr_ff == LW'(lph_pkg::MAX_SLOTS - 1));
      stat.slot_empty = (slot_rd == '0);
      stat.key_match  = !mismatch;
      stat.probe_last = (probe_ff == size_eff - SW'(1));
      stat.mode       = mode_ff;
   end

   assign rsp_status      = status_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_entry_count = count_ff;

endmodule
